// File: rtl/blps_pkg.sv
// types, codes and the mode transition table of the button/led pattern sequencer
// no dependencies; used by button_led_pattern_sequencer_unit

package blps_pkg;

    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned PERIOD_W    = 16;
    localparam int unsigned LEVEL_W     = 8;
    localparam int unsigned LED_W       = 4;
    localparam int unsigned EDGE_W      = 3;

    localparam logic [LEVEL_W-1:0]  LEVEL_MAX = 8'd255;
    localparam logic [PERIOD_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PERIOD_FORWARD = 3'd0,
        CFG_PERIOD_BLINK   = 3'd1,
        CFG_PERIOD_REVERSE = 3'd2,
        CFG_PERIOD_BREATHE = 3'd3,
        CFG_DEBOUNCE       = 3'd4,
        CFG_BREATHE_STEP   = 3'd5
    } t_cfg_index;

    typedef enum logic [1:0] {
        MODE_FORWARD = 2'd0,
        MODE_BLINK   = 2'd1,
        MODE_REVERSE = 2'd2,
        MODE_BREATHE = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        EVT_BUTTON1 = 2'd0,
        EVT_BUTTON2 = 2'd1,
        EVT_BUTTON3 = 2'd2
    } t_event;

    localparam logic [PERIOD_W-1:0] RST_PERIOD_FORWARD = 16'd200;
    localparam logic [PERIOD_W-1:0] RST_PERIOD_BLINK   = 16'd500;
    localparam logic [PERIOD_W-1:0] RST_PERIOD_REVERSE = 16'd200;
    localparam logic [PERIOD_W-1:0] RST_PERIOD_BREATHE = 16'd30;
    localparam logic [PERIOD_W-1:0] RST_DEBOUNCE       = 16'd200;
    localparam logic [LEVEL_W-1:0]  RST_BREATHE_STEP   = 8'd5;

    localparam logic [1:0] RST_REVERSE_POS = 2'd3;

    // mode transition on a dequeued button event
    function automatic t_mode next_mode(input t_mode cur, input t_event evt);
        t_mode res;
        res = cur;
        case (cur)
            MODE_FORWARD: begin
                case (evt)
                    EVT_BUTTON1: res = MODE_REVERSE;
                    EVT_BUTTON2: res = MODE_BLINK;
                    EVT_BUTTON3: res = MODE_BREATHE;
                    default:     res = cur;
                endcase
            end
            MODE_BLINK: begin
                case (evt)
                    EVT_BUTTON1: res = MODE_FORWARD;
                    EVT_BUTTON2: res = MODE_REVERSE;
                    EVT_BUTTON3: res = MODE_BREATHE;
                    default:     res = cur;
                endcase
            end
            MODE_REVERSE: begin
                case (evt)
                    EVT_BUTTON1: res = MODE_BLINK;
                    EVT_BUTTON2: res = MODE_FORWARD;
                    EVT_BUTTON3: res = MODE_BREATHE;
                    default:     res = cur;
                endcase
            end
            MODE_BREATHE: res = MODE_FORWARD;
            default:      res = cur;
        endcase
        return res;
    endfunction

endpackage

// File: rtl/button_led_pattern_sequencer_unit.sv
// top level of the button/led pattern sequencer: debounce, event queue, mode patterns
// depends on blps_pkg

// One input transaction is one millisecond tick carrying the falling-edge flags of
// three buttons; every tick yields exactly one result transaction with the led drive,
// the pwm flag and level for led0, and the current mode. A new tick is taken every
// clock cycle unless o_in_stall is raised: the tick goes into an input register,
// and the whole update (debounce, queue push and pop, pattern step) runs from there
// combinationally into the state and the result register, which drives the outputs.
// The result register holds its value while the downstream side stalls, and the
// input register keeps taking a tick until it too is full. Configuration writes are
// meant for idle periods only.

module button_led_pattern_sequencer_unit #(
    parameter int unsigned QUEUE_DEPTH = 10
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration
    input  logic                                  i_cfg_we,
    input  logic [blps_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [blps_pkg::CFG_DATA_W-1:0]       i_cfg_wdata,
    // tick input
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [blps_pkg::EDGE_W-1:0]           i_button_edges,
    // result output
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [blps_pkg::LED_W-1:0]            o_led_levels,
    output logic                                  o_pwm_active,
    output logic [blps_pkg::LEVEL_W-1:0]          o_pwm_level,
    output logic [1:0]                            o_mode_now
);

    localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned SUM_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(QUEUE_DEPTH - 1);

    // configuration registers
    logic [blps_pkg::PERIOD_W-1:0] r_period_forward;
    logic [blps_pkg::PERIOD_W-1:0] r_period_blink;
    logic [blps_pkg::PERIOD_W-1:0] r_period_reverse;
    logic [blps_pkg::PERIOD_W-1:0] r_period_breathe;
    logic [blps_pkg::PERIOD_W-1:0] r_debounce;
    logic [blps_pkg::LEVEL_W-1:0]  r_breathe_step;

    // input register
    logic                          r_in_valid;
    logic [blps_pkg::EDGE_W-1:0]   r_in_edges;

    // sequencer state
    blps_pkg::t_mode               r_mode,       n_mode;
    logic [blps_pkg::PERIOD_W-1:0] r_countdown,  n_countdown;
    blps_pkg::t_event              r_q_mem [QUEUE_DEPTH];
    logic [IDX_W-1:0]              r_q_head,     n_q_head;
    logic [CNT_W-1:0]              r_q_count,    n_q_count;
    logic [blps_pkg::PERIOD_W-1:0] r_since,      n_since;
    logic [1:0]                    r_fwd_pos,    n_fwd_pos;
    logic [1:0]                    r_rev_pos,    n_rev_pos;
    logic                          r_blink_ph,   n_blink_ph;
    logic [blps_pkg::LEVEL_W-1:0]  r_bright,     n_bright;
    logic                          r_dimming,    n_dimming;
    logic [blps_pkg::LED_W-1:0]    r_leds,       n_leds;

    // result register
    logic                          r_out_valid;
    logic [blps_pkg::LED_W-1:0]    r_out_leds;
    logic                          r_out_pwm_active;
    logic [blps_pkg::LEVEL_W-1:0]  r_out_pwm_level;
    blps_pkg::t_mode               r_out_mode;

    // combinational work
    logic                          out_free;
    logic                          proc;
    logic                          in_accept;
    logic                          press_ok;
    logic                          push;
    logic                          pop;
    blps_pkg::t_event              press_evt;
    blps_pkg::t_event              deq_evt;
    logic [SUM_W-1:0]              tail_sum;
    logic [IDX_W-1:0]              tail_idx;
    logic [blps_pkg::PERIOD_W-1:0] new_period;
    logic signed [9:0]             breathe_sum;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        press_ok  = (r_in_edges != '0) && (r_since >= r_debounce);
        press_evt = r_in_edges[0] ? blps_pkg::EVT_BUTTON1 :
                    (r_in_edges[1] ? blps_pkg::EVT_BUTTON2 : blps_pkg::EVT_BUTTON3);
        push      = press_ok && (r_q_count < DEPTH_CNT);

        // write slot = (head + count) mod depth, sum stays below twice the depth
        tail_sum = SUM_W'(r_q_head) + SUM_W'(r_q_count);
        if (tail_sum >= DEPTH_SUM) begin
            tail_sum = tail_sum - DEPTH_SUM;
        end
        tail_idx = tail_sum[IDX_W-1:0];

        // an event pushed this tick into an empty queue can be popped at once
        pop     = (r_countdown == '0) && ((r_q_count != '0) || push);
        deq_evt = (r_q_count != '0) ? r_q_mem[r_q_head] : press_evt;

        n_mode      = r_mode;
        n_countdown = r_countdown;
        n_q_head    = r_q_head;
        n_q_count   = r_q_count + CNT_W'(push) - CNT_W'(pop);
        n_fwd_pos   = r_fwd_pos;
        n_rev_pos   = r_rev_pos;
        n_blink_ph  = r_blink_ph;
        n_bright    = r_bright;
        n_dimming   = r_dimming;
        n_leds      = r_leds;
        new_period  = '0;
        breathe_sum = '0;

        if (press_ok) begin
            n_since = 16'd1;
        end else if (r_since != blps_pkg::COUNT_MAX) begin
            n_since = r_since + 16'd1;
        end else begin
            n_since = r_since;
        end

        if (pop) begin
            n_mode   = blps_pkg::next_mode(r_mode, deq_evt);
            n_q_head = (r_q_head == LAST_IDX) ? '0 : r_q_head + IDX_W'(1);
        end

        if (r_countdown == '0) begin
            case (n_mode)
                blps_pkg::MODE_FORWARD: begin
                    n_leds     = blps_pkg::LED_W'(1) << r_fwd_pos;
                    n_fwd_pos  = r_fwd_pos + 2'd1;
                    new_period = r_period_forward;
                end
                blps_pkg::MODE_BLINK: begin
                    n_leds     = r_blink_ph ? '1 : '0;
                    n_blink_ph = !r_blink_ph;
                    new_period = r_period_blink;
                end
                blps_pkg::MODE_REVERSE: begin
                    n_leds     = blps_pkg::LED_W'(1) << r_rev_pos;
                    n_rev_pos  = r_rev_pos - 2'd1;
                    new_period = r_period_reverse;
                end
                default: begin
                    if (r_dimming) begin
                        breathe_sum = $signed({2'b00, r_bright}) -
                                      $signed({2'b00, r_breathe_step});
                    end else begin
                        breathe_sum = $signed({2'b00, r_bright}) +
                                      $signed({2'b00, r_breathe_step});
                    end
                    // clamp at either end and turn around
                    if (breathe_sum >= 10'sd255) begin
                        n_bright  = blps_pkg::LEVEL_MAX;
                        n_dimming = !r_dimming;
                    end else if (breathe_sum <= 10'sd0) begin
                        n_bright  = '0;
                        n_dimming = !r_dimming;
                    end else begin
                        n_bright  = breathe_sum[blps_pkg::LEVEL_W-1:0];
                    end
                    n_leds     = '0;
                    new_period = r_period_breathe;
                end
            endcase
            // a zero period behaves as one
            n_countdown = (new_period == '0) ? '0 : new_period - 16'd1;
        end else begin
            n_countdown = r_countdown - 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_forward <= blps_pkg::RST_PERIOD_FORWARD;
            r_period_blink   <= blps_pkg::RST_PERIOD_BLINK;
            r_period_reverse <= blps_pkg::RST_PERIOD_REVERSE;
            r_period_breathe <= blps_pkg::RST_PERIOD_BREATHE;
            r_debounce       <= blps_pkg::RST_DEBOUNCE;
            r_breathe_step   <= blps_pkg::RST_BREATHE_STEP;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                blps_pkg::CFG_PERIOD_FORWARD: r_period_forward <= i_cfg_wdata;
                blps_pkg::CFG_PERIOD_BLINK:   r_period_blink   <= i_cfg_wdata;
                blps_pkg::CFG_PERIOD_REVERSE: r_period_reverse <= i_cfg_wdata;
                blps_pkg::CFG_PERIOD_BREATHE: r_period_breathe <= i_cfg_wdata;
                blps_pkg::CFG_DEBOUNCE:       r_debounce       <= i_cfg_wdata;
                blps_pkg::CFG_BREATHE_STEP:
                    r_breathe_step <= i_cfg_wdata[blps_pkg::LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_edges <= i_button_edges;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= blps_pkg::MODE_FORWARD;
            r_countdown <= '0;
            r_q_head    <= '0;
            r_q_count   <= '0;
            r_since     <= '0;
            r_fwd_pos   <= '0;
            r_rev_pos   <= blps_pkg::RST_REVERSE_POS;
            r_blink_ph  <= 1'b0;
            r_bright    <= '0;
            r_dimming   <= 1'b0;
            r_leds      <= '0;
        end else if (proc) begin
            r_mode      <= n_mode;
            r_countdown <= n_countdown;
            r_q_head    <= n_q_head;
            r_q_count   <= n_q_count;
            r_since     <= n_since;
            r_fwd_pos   <= n_fwd_pos;
            r_rev_pos   <= n_rev_pos;
            r_blink_ph  <= n_blink_ph;
            r_bright    <= n_bright;
            r_dimming   <= n_dimming;
            r_leds      <= n_leds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && push) begin
            r_q_mem[tail_idx] <= press_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out_leds       <= n_leds;
            r_out_pwm_active <= (n_mode == blps_pkg::MODE_BREATHE);
            r_out_pwm_level  <= (n_mode == blps_pkg::MODE_BREATHE) ? n_bright : '0;
            r_out_mode       <= n_mode;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_led_levels = r_out_leds;
    assign o_pwm_active = r_out_pwm_active;
    assign o_pwm_level  = r_out_pwm_level;
    assign o_mode_now   = r_out_mode;

    // queue occupancy never passes its depth
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_count <= DEPTH_CNT)
        else $error("event queue count above depth");

    // occupancy stays put unless a tick is processed
    a_queue_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !proc |=> (r_q_count == $past(r_q_count)))
        else $error("event queue count changed without a tick");

    // breathing mode drives pwm and turns the on/off leds off
    a_breathe_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_pwm_active == (o_mode_now == blps_pkg::MODE_BREATHE)) &&
                         (o_pwm_active || (o_pwm_level == '0)) &&
                         (!o_pwm_active || (o_led_levels == '0))))
        else $error("pwm outputs inconsistent with mode");

    // a stalled tick leaves the sequencer state alone
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !proc) |=> ($stable(r_mode) && $stable(r_countdown) &&
                                   $stable(r_since)))
        else $error("state changed while the input register was blocked");

endmodule
